// ----- rtl/core/pcs_pkg.sv -----
// pcs_pkg: shared types and constants for the percentile contrast stretch core
// no dependencies
package pcs_pkg;
   localparam int unsigned BIN_W    = 8;
   localparam int unsigned CNT_W    = 23;
   localparam int unsigned CLIP_W   = 13;
   localparam int unsigned BND_W    = 10;
   localparam logic [CNT_W-1:0]  COUNT_SAT  = 23'h7FFFFF;
   localparam logic [CLIP_W-1:0] CLIP_LIMIT = 13'd4999;
   localparam logic [CLIP_W-1:0] CLIP_RESET = 13'd100;

   typedef enum logic {
      FUNC_ACC = 1'b0,
      FUNC_MAP = 1'b1
   } func_type;

   typedef struct packed {
      func_type        func;
      logic [1:0]      channel;
      logic [7:0]      pixel;
      logic            frame_last;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_NEED,
      ST_WALK_UP,
      ST_WALK_DN,
      ST_SETTLE,
      ST_CLEAR,
      ST_MAP_DIV,
      ST_MAP_OUT,
      ST_INIT
   } state_type;
endpackage

// ----- rtl/core/pcs_stream_if.sv -----
// pcs_stream_if: valid/ready channel carrying a packed payload
// no dependencies
interface pcs_stream_if #(
   parameter int unsigned WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/percentile_contrast_stretch_core.sv -----
// percentile_contrast_stretch_core: top level of the per-channel auto-levels block
// depends on pcs_pkg, pcs_stream_if, pcs_front, pcs_queue, pcs_back
// An accumulate item reads its histogram bin in ST_ACC_RD and writes the
// incremented count back in ST_ACC_WR; a frame_last item then computes the
// clip count (multiply, then reciprocal multiply for the divide by 10000),
// walks the bins up and down, settles the bounds and clears the channel's
// bins. A map item runs through the serial divider. After reset all
// NUM_CHANNELS*256 histogram entries are cleared before the first item is
// processed; items queue meanwhile.
module percentile_contrast_stretch_core
   import pcs_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 3
) (
   input  logic              clock,
   input  logic              reset,
   pcs_stream_if.sink        req,
   pcs_stream_if.source      rsp,
   input  logic              csr_wr_en,
   input  logic [CLIP_W-1:0] csr_wr_data
);
   logic [CLIP_W-1:0] clip_ff;
   logic    q_full, q_push, q_empty, q_pop;
   cmd_type q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) clip_ff <= CLIP_RESET;
      else if (csr_wr_en) clip_ff <= csr_wr_data;
   end

   pcs_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .req(req), .q_full(q_full), .q_push(q_push), .q_cmd(q_in)
   );
   pcs_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_cmd(q_in), .full(q_full),
      .pop(q_pop), .pop_cmd(q_out), .empty(q_empty)
   );
   pcs_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock(clock), .reset(reset), .clip(clip_ff), .q_empty(q_empty),
      .q_cmd(q_out), .q_pop(q_pop), .rsp(rsp)
   );
endmodule

// ----- rtl/core/pcs_ram.sv -----
// pcs_ram: generic single-port-write, one-read ram with registered read
// no dependencies
module pcs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/pcs_queue.sv -----
// pcs_queue: short command queue between the front and back parts
// depends on pcs_pkg
module pcs_queue
   import pcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push && !full) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop && !empty) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
      end
   end
endmodule

// ----- rtl/core/pcs_front.sv -----
// pcs_front: accepts items, drops accumulate items for absent channels
// depends on pcs_pkg, pcs_stream_if
module pcs_front
   import pcs_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 3
) (
   pcs_stream_if.sink req,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);
   cmd_type cmd;
   assign cmd       = cmd_type'(req.data);
   assign req.ready = !q_full;
   // accumulate items for a channel that does not exist have no effect
   assign q_push = req.valid && !q_full &&
                   !(cmd.func == FUNC_ACC && {30'd0, cmd.channel} >= NUM_CHANNELS);
   assign q_cmd  = cmd;
endmodule

// ----- rtl/core/pcs_back.sv -----
// pcs_back: histogram accumulation, percentile walks and pixel mapping
// depends on pcs_pkg, pcs_ram, pcs_stream_if
module pcs_back
   import pcs_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CLIP_W-1:0] clip,
   input  logic              q_empty,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   pcs_stream_if.source      rsp
);
   localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int unsigned DEPTH = NUM_CHANNELS * 256;
   localparam int unsigned AW    = $clog2(DEPTH);
   // ceil(2^41/625): floor(y/625) == (y*RECIP_625) >> 41 for any y below 2^32
   localparam logic [31:0] RECIP_625 = 32'd3518437209;

   state_type state_ff, state_in;
   cmd_type   cur_ff, cur_in;
   logic [CNT_W-1:0] cnt_ff  [NUM_CHANNELS];
   logic [7:0]       min_ff  [NUM_CHANNELS];
   logic [7:0]       max_ff  [NUM_CHANNELS];
   logic signed [BND_W-1:0] lo_ff [NUM_CHANNELS];
   logic signed [BND_W-1:0] hi_ff [NUM_CHANNELS];
   logic [8:0]  idx_ff, idx_in;          // walk / clear index, 0..256
   logic [8:0]  up_ff, up_in;
   logic [35:0] prod_ff, prod_in;
   logic [63:0] recip_ff, recip_in;
   logic [CNT_W-1:0] need_ff, need_in;
   logic [CNT_W+8:0] acc_ff, acc_in;
   logic [9:0]  init_ff, init_in;
   // divider
   logic [17:0] rem_ff, rem_in;
   logic [17:0] num_ff, num_in;
   logic [9:0]  den_ff, den_in;
   logic [4:0]  dstep_ff, dstep_in;
   logic        neg_ff, neg_in, pass_ff, pass_in;
   logic        out_v_ff, out_v_in;
   logic [1:0]  out_ch_ff, out_ch_in;
   logic [7:0]  out_px_ff, out_px_in;

   logic            ram_we;
   logic [AW-1:0]   ram_wa, ram_ra;
   logic [CNT_W-1:0] ram_wd, ram_rd;
   logic [CH_W-1:0] ch;
   logic            ch_ok;
   logic [12:0]     clip_sat;
   logic            upd_stats;

   assign ch    = cur_ff.channel[CH_W-1:0];
   assign ch_ok = {30'd0, cur_ff.channel} < NUM_CHANNELS;
   assign clip_sat = (clip > CLIP_LIMIT) ? CLIP_LIMIT : clip;

   pcs_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_hist (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   function automatic logic [AW-1:0] baddr(input logic [CH_W-1:0] c,
                                           input logic [7:0] b);
      logic [AW+8:0] a;
      a = ({{(AW+9-CH_W){1'b0}}, c} << 8) + {{(AW+1){1'b0}}, b};
      return a[AW-1:0];
   endfunction

   always_comb begin
      logic signed [BND_W-1:0] lo, hi, sd;
      logic signed [BND_W:0]   sn;
      logic [17:0] r2;
      logic [8:0]  walk_b;
      state_in  = state_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      up_in     = up_ff;
      prod_in   = prod_ff;
      recip_in  = recip_ff;
      need_in   = need_ff;
      acc_in    = acc_ff;
      init_in   = init_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      dstep_in  = dstep_ff;
      neg_in    = neg_ff;
      pass_in   = pass_ff;
      out_v_in  = out_v_ff;
      out_ch_in = out_ch_ff;
      out_px_in = out_px_ff;
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_wa    = baddr(ch, cur_ff.pixel);
      ram_wd    = '0;
      ram_ra    = baddr(ch, cur_ff.pixel);
      upd_stats = 1'b0;
      lo = lo_ff[ch];
      hi = hi_ff[ch];
      sd = hi - lo;
      sn = $signed({3'b000, cur_ff.pixel}) - $signed({lo[BND_W-1], lo});
      r2 = '0;
      walk_b = '0;
      if (rsp.valid && rsp.ready) out_v_in = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // clearing pass over the histogram memory
            ram_we  = 1'b1;
            ram_wa  = init_ff[AW-1:0];
            ram_wd  = '0;
            init_in = init_ff + 10'd1;
            if ({22'd0, init_ff} == DEPTH - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_cmd;
               state_in = (q_cmd.func == FUNC_ACC) ? ST_ACC_RD : ST_MAP_DIV;
               dstep_in = '0;
            end
         end
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: begin
            ram_we = 1'b1;
            ram_wd = (ram_rd < COUNT_SAT) ? ram_rd + 1'b1 : ram_rd;
            upd_stats = 1'b1;
            prod_in = '0;
            state_in = cur_ff.frame_last ? ST_NEED : ST_IDLE;
         end
         ST_NEED: begin
            // need = floor(count*clip/10000) = floor(floor(p/16)/625)
            if (dstep_ff == 5'd0) begin
               prod_in  = {13'd0, cnt_ff[ch]} * {23'd0, clip_sat};
               dstep_in = 5'd1;
            end else if (dstep_ff == 5'd1) begin
               // product stays below 2^36, so p/16 fits in 32 bits
               recip_in = {32'd0, prod_ff[35:4]} * {32'd0, RECIP_625};
               dstep_in = 5'd2;
            end else begin
               need_in  = recip_ff[63:41];
               state_in = ST_WALK_UP;
               idx_in   = '0;
               acc_in   = '0;
            end
         end
         ST_WALK_UP: begin
            // idx_ff: bins consumed; read of bin idx_ff issued previous cycle
            // dstep 0: issue read; dstep 1: add
            walk_b = idx_ff;
            ram_ra = baddr(ch, walk_b[7:0]);
            if (dstep_ff == 5'd0) begin
               if ({9'd0, acc_ff[CNT_W+8:0]} >= {9'd0, 9'd0, need_ff} || idx_ff == 9'd256)
               begin
                  up_in = idx_ff;
                  idx_in = '0;
                  acc_in = '0;
                  state_in = ST_WALK_DN;
               end else begin
                  dstep_in = 5'd1;
               end
            end else begin
               acc_in = acc_ff + {9'd0, ram_rd};
               idx_in = idx_ff + 9'd1;
               dstep_in = 5'd0;
            end
         end
         ST_WALK_DN: begin
            walk_b = 9'd255 - idx_ff;
            ram_ra = baddr(ch, walk_b[7:0]);
            if (dstep_ff == 5'd0) begin
               if (acc_ff >= {9'd0, need_ff} || idx_ff == 9'd256) begin
                  state_in = ST_SETTLE;
               end else begin
                  dstep_in = 5'd1;
               end
            end else begin
               acc_in = acc_ff + {9'd0, ram_rd};
               idx_in = idx_ff + 9'd1;
               dstep_in = 5'd0;
            end
         end
         ST_SETTLE: begin
            idx_in = '0;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = baddr(ch, idx_ff[7:0]);
            ram_wd = '0;
            idx_in = idx_ff + 9'd1;
            if (idx_ff == 9'd255) state_in = ST_IDLE;
         end
         ST_MAP_DIV: begin
            if (dstep_ff == 5'd0) begin
               pass_in = !ch_ok || (lo == hi);
               neg_in  = (sn < 0) != (sd < 0);
               num_in  = (sn < 0) ? 18'(-(sn * 11'sd255)) : 18'(sn * 11'sd255);
               den_in  = (sd < 0) ? 10'(-sd) : 10'(sd);
               rem_in  = '0;
               dstep_in = 5'd1;
            end else begin
               r2 = {rem_ff[16:0], num_ff[17]};
               num_in = {num_ff[16:0], 1'b0};
               if (r2 >= {8'd0, den_ff}) begin
                  rem_in = r2 - {8'd0, den_ff};
                  num_in[0] = 1'b1;
               end else begin
                  rem_in = r2;
               end
               dstep_in = dstep_ff + 5'd1;
               if (dstep_ff == 5'd18) state_in = ST_MAP_OUT;
            end
         end
         ST_MAP_OUT: begin
            if (!out_v_in) begin
               out_v_in  = 1'b1;
               out_ch_in = cur_ff.channel;
               if (pass_ff) out_px_in = cur_ff.pixel;
               else if (neg_ff && num_ff != 18'd0) out_px_in = 8'd0;
               else if (num_ff > 18'd255) out_px_in = 8'd255;
               else out_px_in = num_ff[7:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = {out_ch_ff, out_px_ff};

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; idx_ff <= idx_in; up_ff <= up_in; prod_ff <= prod_in;
      recip_ff <= recip_in;
      need_ff <= need_in; acc_ff <= acc_in; rem_ff <= rem_in; num_ff <= num_in;
      den_ff <= den_in; neg_ff <= neg_in; pass_ff <= pass_in;
      out_ch_ff <= out_ch_in; out_px_ff <= out_px_in;
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff  <= '0;
         out_v_ff <= 1'b0;
         dstep_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cnt_ff[i] <= '0; min_ff[i] <= 8'd255; max_ff[i] <= 8'd0;
            lo_ff[i] <= '0; hi_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         out_v_ff <= out_v_in;
         dstep_ff <= (state_in != state_ff) && state_ff != ST_IDLE ? 5'd0 : dstep_in;
         if (upd_stats) begin
            if (cnt_ff[ch] < COUNT_SAT) cnt_ff[ch] <= cnt_ff[ch] + 1'b1;
            if (cur_ff.pixel < min_ff[ch]) min_ff[ch] <= cur_ff.pixel;
            if (cur_ff.pixel > max_ff[ch]) max_ff[ch] <= cur_ff.pixel;
         end
         if (state_ff == ST_SETTLE) begin
            lo_ff[ch] <= ({1'b0, up_ff} > {2'b00, min_ff[ch]}) ?
                         $signed({1'b0, up_ff}) : $signed({2'b00, min_ff[ch]});
            // down stop = 255 - walked
            hi_ff[ch] <= ($signed(10'sd255 - $signed({1'b0, idx_ff})) <
                          $signed({2'b00, max_ff[ch]})) ?
                         (10'sd255 - $signed({1'b0, idx_ff})) :
                         $signed({2'b00, max_ff[ch]});
            cnt_ff[ch] <= '0; min_ff[ch] <= 8'd255; max_ff[ch] <= 8'd0;
         end
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result dropped while stalled");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("queue popped while busy");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_UP || state_ff == ST_WALK_DN) |-> idx_ff <= 9'd256)
      else $error("walk overran bins");
endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for percentile_contrast_stretch_core
// depends on pcs_pkg, pcs_stream_if and the core rtl
module tb;
   import pcs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = 3;
   localparam int REQ_W = $bits(cmd_type);
   // worst case frame-end work plus slack, in cycles
   localparam int SETTLE_WAIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CLIP_W-1:0] csr_wr_data = '0;

   always #1 clock = ~clock;

   pcs_stream_if #(.WIDTH(REQ_W)) req ();
   pcs_stream_if #(.WIDTH(10)) rsp ();

   percentile_contrast_stretch_core #(.NUM_CHANNELS(NCH)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // shadow state of the stretch core
   logic [CLIP_W-1:0] clip_setting;
   int unsigned hist [NCH][256];
   int unsigned frame_count [NCH];
   int lo_seen [NCH];
   int hi_seen [NCH];
   int lo_bnd [NCH];
   int hi_bnd [NCH];

   logic [9:0] pending_pixels [$];
   int errors = 0;
   int sent = 0;
   int mapped = 0;
   int frames = 0;
   bit quiet = 1'b0;   // when set, both sides run without idling

   function automatic void clear_chan(int c);
      for (int b = 0; b < 256; b++) hist[c][b] = 0;
      frame_count[c] = 0;
      lo_seen[c] = 255;
      hi_seen[c] = 0;
   endfunction

   // frame end: clip count, walk both ends, latch bounds
   function automatic void settle_chan(int c);
      longint need, acc;
      int up, dn, clip;
      clip = (clip_setting > CLIP_LIMIT) ? int'(CLIP_LIMIT) : int'(clip_setting);
      need = (longint'(frame_count[c]) * clip) / 10000;
      acc = 0;
      up = 0;
      while (acc < need && up < 256) begin
         acc += hist[c][up];
         up++;
      end
      acc = 0;
      dn = 255;
      while (acc < need && dn >= 0) begin
         acc += hist[c][dn];
         dn--;
      end
      lo_bnd[c] = (up > lo_seen[c]) ? up : lo_seen[c];
      hi_bnd[c] = (dn < hi_seen[c]) ? dn : hi_seen[c];
      clear_chan(c);
      frames++;
   endfunction

   // apply one item to the shadow state, queue its mapped pixel if any
   function automatic void stretch_item(cmd_type cmd);
      int c, v, q;
      c = cmd.channel;
      v = cmd.pixel;
      if (cmd.func == FUNC_ACC) begin
         if (c >= NCH) return;
         if (hist[c][v] < COUNT_SAT) hist[c][v]++;
         if (frame_count[c] < COUNT_SAT) frame_count[c]++;
         if (v < lo_seen[c]) lo_seen[c] = v;
         if (v > hi_seen[c]) hi_seen[c] = v;
         if (cmd.frame_last) settle_chan(c);
      end else begin
         q = v;
         if (c < NCH && lo_bnd[c] != hi_bnd[c]) begin
            q = (255 * (v - lo_bnd[c])) / (hi_bnd[c] - lo_bnd[c]);
            if (q > 255) q = 255;
            if (q < 0) q = 0;
         end
         pending_pixels.push_back({cmd.channel, q[7:0]});
      end
   endfunction

   // send one item, with random idle cycles before it
   task automatic send_item(cmd_type cmd);
      while (!quiet && $urandom_range(99) < 13) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= cmd;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      stretch_item(cmd);
      sent++;
   endtask

   // hold off until the block has drained, then allow frame-end work to finish
   task automatic drain_all();
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_clip(logic [CLIP_W-1:0] val);
      drain_all();
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clip_setting = val;
   endtask

   function automatic cmd_type mk(func_type f, int c, int p, bit l);
      cmd_type cmd;
      cmd.func = f;
      cmd.channel = c[1:0];
      cmd.pixel = p[7:0];
      cmd.frame_last = l;
      return cmd;
   endfunction

   // sink side: random stalls, compare each mapped pixel with the oldest expected one
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected result ch=%0d pix=%0d", $time,
                        rsp.data[9:8], rsp.data[7:0]);
               errors++;
            end else begin
               if (rsp.data[9:8] !== pending_pixels[0][9:8]) begin
                  $display("%0t: out_channel expected %0d actual %0d", $time,
                           pending_pixels[0][9:8], rsp.data[9:8]);
                  errors++;
               end
               if (rsp.data[7:0] !== pending_pixels[0][7:0]) begin
                  $display("%0t: out_pixel expected %0d actual %0d", $time,
                           pending_pixels[0][7:0], rsp.data[7:0]);
                  errors++;
               end
               void'(pending_pixels.pop_front());
               mapped++;
            end
         end
         rsp.ready <= quiet || ($urandom_range(99) >= 13);
      end
   end

   // table of directed items; expected pixel typed in where it is obvious
   typedef struct {
      cmd_type cmd;
      int      want;   // -1: predictor only
   } row_type;

   row_type rows [$];

   // random frame on one channel, then some map items across channels
   task automatic random_frame(int len);
      int c, base, spread;
      c = $urandom_range(NCH - 1);
      base = $urandom_range(255);
      spread = $urandom_range(255);
      for (int i = 0; i < len; i++) begin
         int p;
         p = ($urandom_range(9) == 0) ? $urandom_range(255)
             : (base + $urandom_range(spread)) % 256;
         send_item(mk(FUNC_ACC, c, p, i == len - 1));
      end
      repeat ($urandom_range(20, 4))
         send_item(mk(FUNC_MAP, $urandom_range(3), $urandom_range(255), $urandom_range(1)));
   endtask

   initial begin
      req.valid <= 1'b0;
      req.data <= '0;
      clip_setting = CLIP_RESET;
      for (int c = 0; c < NCH; c++) begin
         clear_chan(c);
         lo_bnd[c] = 0;
         hi_bnd[c] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // map before any frame passes through, including an invalid channel
      rows.push_back('{mk(FUNC_MAP, 0, 0, 0), 0});
      rows.push_back('{mk(FUNC_MAP, 1, 255, 1), 255});
      rows.push_back('{mk(FUNC_MAP, 2, 128, 0), 128});
      rows.push_back('{mk(FUNC_MAP, 3, 77, 0), 77});
      // ignored accumulate on the invalid channel, frame_last too
      rows.push_back('{mk(FUNC_ACC, 3, 9, 1), -1});
      // channel 0 frame of two pixels 0 and 255, no clipping at count 2
      rows.push_back('{mk(FUNC_ACC, 0, 0, 0), -1});
      rows.push_back('{mk(FUNC_ACC, 0, 255, 1), -1});
      rows.push_back('{mk(FUNC_MAP, 0, 0, 0), 0});
      rows.push_back('{mk(FUNC_MAP, 0, 255, 0), 255});
      rows.push_back('{mk(FUNC_MAP, 0, 100, 0), -1});
      // single-pixel frame: equal bounds, pass-through
      rows.push_back('{mk(FUNC_ACC, 1, 42, 1), -1});
      rows.push_back('{mk(FUNC_MAP, 1, 200, 0), 200});
      // narrow frame on channel 2 clamps outside values
      rows.push_back('{mk(FUNC_ACC, 2, 100, 0), -1});
      rows.push_back('{mk(FUNC_ACC, 2, 110, 1), -1});
      rows.push_back('{mk(FUNC_MAP, 2, 0, 0), 0});
      rows.push_back('{mk(FUNC_MAP, 2, 255, 0), 255});
      rows.push_back('{mk(FUNC_MAP, 2, 105, 0), -1});
      rows.push_back('{mk(FUNC_MAP, 3, 0, 1), 0});
      foreach (rows[i]) begin
         if (rows[i].want >= 0 && rows[i].cmd.func == FUNC_MAP) begin
            int p;
            send_item(rows[i].cmd);
            p = pending_pixels[$][7:0];
            if (p != rows[i].want) begin
               $display("%0t: directed row %0d expected %0d predicted %0d", $time, i,
                        rows[i].want, p);
               errors++;
            end
         end else begin
            send_item(rows[i].cmd);
         end
      end

      // sweep of clip settings; zero, the limit, above it and the register max
      begin
         logic [CLIP_W-1:0] clips [6];
         clips = '{13'd0, 13'd4999, 13'd8191, 13'd250, 13'd5000, 13'd1200};
         foreach (clips[k]) begin
            write_clip(clips[k]);
            if (k == 2) quiet = 1'b1;   // one phase without idling
            if (k == 3) quiet = 1'b0;
            while (sent < 18 + (k + 1) * 225) random_frame($urandom_range(60, 3));
         end
      end
      // a random clip value, plus a frame with every bit pattern of pixels
      write_clip(CLIP_W'($urandom_range(8191)));
      for (int p = 0; p < 256; p++) send_item(mk(FUNC_ACC, 0, p, p == 255));
      for (int p = 0; p < 256; p += 17) send_item(mk(FUNC_MAP, 0, p, 0));

      drain_all();
      $display("covered %0d items, %0d frames settled, %0d mapped pixels checked",
               sent, frames, mapped);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
